>>> sv/etdf_pkg.sv
// ----------------------------------------------------------------------------
// etdf_pkg: shared types and constants for the EMG feature extractor
// Field widths, saturation limits, sign codes and the per-channel record.
// ----------------------------------------------------------------------------
package etdf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHAN_W    = 3;
  localparam int WIN_W     = 11;
  localparam int THR_W     = 15;
  localparam int SUM_W     = 26;
  localparam int CNT_W     = 10;
  localparam int MEAN_W    = 24;
  localparam int MEAN_FRAC = 8;
  localparam int DIVD_W    = SUM_W + MEAN_FRAC;

  localparam int CHANNELS_DEF   = 8;
  localparam int MAX_WINDOW_DEF = 1024;

  localparam logic [WIN_W-1:0] WIN_MIN      = WIN_W'(3);
  localparam logic [WIN_W-1:0] WIN_RESET    = WIN_W'(100);
  localparam logic [WIN_W-1:0] WIN_REG_MAX  = '1;
  localparam logic [SUM_W-1:0] SUM_MAX      = '1;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [MEAN_W-1:0] MEAN_MAX    = '1;

  // configuration register indexes
  localparam logic CFG_WINDOW_SIZE  = 1'b0;
  localparam logic CFG_ZC_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic [WIN_W-1:0]           count;
    logic [SUM_W-1:0]           abs_sum;
    logic [SUM_W-1:0]           len_sum;
    logic [CNT_W-1:0]           ext_cnt;
    logic [CNT_W-1:0]           zc_cnt;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] older;
    sign_t                      last_sign;
  } ch_rec_t;

endpackage

>>> sv/etdf_update.sv
// ----------------------------------------------------------------------------
// etdf_update: per-sample channel record update
// Folds one sample into a channel's running window accumulators.
// ----------------------------------------------------------------------------
module etdf_update (
  input  logic signed [etdf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 open_i,
  input  logic [etdf_pkg::THR_W-1:0]           thr_i,
  input  etdf_pkg::ch_rec_t                    rec_i,
  output etdf_pkg::ch_rec_t                    rec_o
);
  import etdf_pkg::*;

  logic signed [SAMPLE_W:0] x_ext;
  logic signed [SAMPLE_W:0] b_ext;
  logic signed [SAMPLE_W:0] d_xb;
  logic signed [SAMPLE_W:0] d1;
  logic signed [SAMPLE_W:0] d2;
  logic [SAMPLE_W:0]        mag_x;
  logic [SAMPLE_W:0]        mag_d;
  logic [SUM_W:0]           abs_s;
  logic [SUM_W:0]           len_s;
  logic                     is_ext;
  sign_t                    x_sign;
  sign_t                    t_sign;

  always_comb begin
    x_ext  = {sample_i[SAMPLE_W-1], sample_i};
    b_ext  = {rec_i.prev[SAMPLE_W-1], rec_i.prev};
    d_xb   = x_ext - b_ext;
    d1     = b_ext - x_ext;
    d2     = b_ext - {rec_i.older[SAMPLE_W-1], rec_i.older};
    mag_x  = x_ext[SAMPLE_W] ? (SAMPLE_W+1)'(-x_ext) : x_ext;
    mag_d  = d_xb[SAMPLE_W] ? (SAMPLE_W+1)'(-d_xb) : d_xb;
    abs_s  = {1'b0, rec_i.abs_sum} + (SUM_W+1)'(mag_x);
    len_s  = {1'b0, rec_i.len_sum} + (SUM_W+1)'(mag_d);
    is_ext = (rec_i.count >= WIN_W'(2)) &&
             (((d1 > 0) && (d2 > 0)) || ((d1 < 0) && (d2 < 0)));

    if (sample_i > 0) begin
      x_sign = SIGN_POS;
    end else if (sample_i < 0) begin
      x_sign = SIGN_NEG;
    end else begin
      x_sign = SIGN_NONE;
    end
    // small magnitudes count as zero for crossings
    t_sign = (mag_x < (SAMPLE_W+1)'(thr_i)) ? SIGN_NONE : x_sign;

    rec_o = rec_i;
    if (open_i) begin
      rec_o.count     = WIN_W'(1);
      rec_o.abs_sum   = SUM_W'(mag_x);
      rec_o.len_sum   = '0;
      rec_o.ext_cnt   = '0;
      rec_o.zc_cnt    = '0;
      rec_o.older     = '0;
      rec_o.prev      = sample_i;
      rec_o.last_sign = x_sign;
    end else begin
      rec_o.count   = rec_i.count + WIN_W'(1);
      rec_o.abs_sum = abs_s[SUM_W] ? SUM_MAX : abs_s[SUM_W-1:0];
      rec_o.len_sum = len_s[SUM_W] ? SUM_MAX : len_s[SUM_W-1:0];
      if (is_ext && (rec_i.ext_cnt != CNT_MAX)) begin
        rec_o.ext_cnt = rec_i.ext_cnt + CNT_W'(1);
      end
      if (rec_i.last_sign == SIGN_NONE) begin
        rec_o.last_sign = t_sign;
      end else if ((t_sign != SIGN_NONE) && (t_sign != rec_i.last_sign)) begin
        rec_o.last_sign = t_sign;
        if (rec_i.zc_cnt != CNT_MAX) begin
          rec_o.zc_cnt = rec_i.zc_cnt + CNT_W'(1);
        end
      end
      rec_o.older = rec_i.prev;
      rec_o.prev  = sample_i;
    end
  end

endmodule

>>> sv/etdf_div.sv
// ----------------------------------------------------------------------------
// etdf_div: iterative restoring divider for the mean
// One quotient bit per cycle; quotient saturates to the mean width.
// ----------------------------------------------------------------------------
module etdf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [etdf_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [etdf_pkg::WIN_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [etdf_pkg::MEAN_W-1:0]   quotient_o
);
  import etdf_pkg::*;

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [WIN_W-1:0]  rem_r;
  logic [WIN_W-1:0]  rem_nxt;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVD_W-1:0] quo_nxt;
  logic [WIN_W-1:0]  dvsr_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic [WIN_W:0]    rem_sh;
  logic [WIN_W:0]    rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr_r};
    fits    = (rem_sh >= {1'b0, dvsr_r});
    rem_nxt = fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DIVD_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      busy_r <= (step_r != STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r  <= '0;
      quo_r  <= dividend_i;
      dvsr_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy_o     = busy_r;
  assign quotient_o = (|quo_r[DIVD_W-1:MEAN_W]) ? MEAN_MAX : quo_r[MEAN_W-1:0];

endmodule

>>> sv/emg_time_domain_features_core.sv
// ----------------------------------------------------------------------------
// emg_time_domain_features_core: per-channel EMG time-domain features
// Accumulates mean absolute value, waveform length, slope sign changes and
// zero crossings per channel and reports them when a window completes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_sample, in_channel, in_window_start) are taken when
//   in_valid is high and in_stall is low. A beat whose channel is not
//   implemented is dropped. Each accepted beat reads its channel record
//   from the state memory, updates it in the next cycle and writes it back;
//   in_stall stays high until that write-back. A beat that closes a window
//   also starts the shared restoring divider for sum*256/window, one quotient
//   bit a cycle, and such a beat keeps in_stall high until the divider is
//   done and the result is loaded. The result beat sits in an output register
//   (out_valid high) until the receiver drops out_stall; meanwhile new input
//   beats are still taken, and only a second completed window waits for the
//   register to free. Configuration (cfg_we, cfg_index, cfg_data) is written
//   only while idle, by the user; the block itself does not enforce it.
//   Reset (rst_n low, synchronous) empties every channel window, sets the
//   window size to 100 and the zero-crossing threshold to 0.
// ----------------------------------------------------------------------------
module emg_time_domain_features_core #(
  parameter int CHANNELS   = etdf_pkg::CHANNELS_DEF,
  parameter int MAX_WINDOW = etdf_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [etdf_pkg::THR_W-1:0]           cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [etdf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [etdf_pkg::CHAN_W-1:0]          in_channel,
  input  logic                                 in_window_start,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [etdf_pkg::CHAN_W-1:0]          out_channel,
  output logic [etdf_pkg::MEAN_W-1:0]          out_mean_abs,
  output logic [etdf_pkg::SUM_W-1:0]           out_wave_length,
  output logic [etdf_pkg::CNT_W-1:0]           out_slope_changes,
  output logic [etdf_pkg::CNT_W-1:0]           out_zero_crossings
);
  import etdf_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // the window register is 11 bits, so a larger limit never bites
  localparam logic [WIN_W-1:0] WIN_MAX =
    (MAX_WINDOW > 2047) ? WIN_REG_MAX : WIN_W'(MAX_WINDOW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV
  } state_t;

  state_t state_r;

  // configuration registers
  logic [WIN_W-1:0] win_size_r;
  logic [THR_W-1:0] zc_thr_r;
  logic [WIN_W-1:0] win_eff;

  // captured input beat
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CHAN_W-1:0]          chan_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       start_r;

  // channel state: record memory plus a live bit per channel
  ch_rec_t                state_mem [CHANNELS];
  ch_rec_t                rd_rec_r;
  ch_rec_t                upd_rec;
  logic [CHANNELS-1:0]    live_r;
  logic                   win_open;
  logic                   win_done;

  // fields held for the pending result while the divider runs
  logic [CHAN_W-1:0] pend_chan_r;
  logic [SUM_W-1:0]  pend_len_r;
  logic [CNT_W-1:0]  pend_ext_r;
  logic [CNT_W-1:0]  pend_zc_r;

  // output register
  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [SUM_W-1:0]  out_len_r;
  logic [CNT_W-1:0]  out_ext_r;
  logic [CNT_W-1:0]  out_zc_r;

  logic              in_accept;
  logic              in_chan_ok;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  logic              div_busy;
  logic [MEAN_W-1:0] div_quo;

  // clamp the window size into its legal range
  always_comb begin
    if (win_size_r < WIN_MIN) begin
      win_eff = WIN_MIN;
    end else if (win_size_r > WIN_MAX) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = win_size_r;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign in_chan_ok = (32'(in_channel) < CHANNELS);
  assign out_free   = !out_valid_r || !out_stall;
  // move the finished window into the output register
  assign out_load   = (state_r == S_DIV) && !div_busy && out_free;

  // a cleared live bit means the channel holds no samples yet
  assign win_open  = start_r || !live_r[idx_r];
  assign win_done  = (upd_rec.count >= win_eff);
  assign div_start = (state_r == S_UPDATE) && win_done;

  etdf_update u_update (
    .sample_i (sample_r),
    .open_i   (win_open),
    .thr_i    (zc_thr_r),
    .rec_i    (rd_rec_r),
    .rec_o    (upd_rec)
  );

  etdf_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i ({upd_rec.abs_sum, MEAN_FRAC'(0)}),
    .divisor_i  (win_eff),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WIN_RESET;
      zc_thr_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  win_size_r <= cfg_data[WIN_W-1:0];
        CFG_ZC_THRESHOLD: zc_thr_r   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // record memory: read on accept, write back after the update
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_rec_r <= state_mem[IDX_W'(in_channel)];
    end
    if (state_r == S_UPDATE) begin
      state_mem[idx_r] <= upd_rec;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new beat, or hold the current one while the receiver stalls
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && in_chan_ok) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // drop the channel back to empty once its window closes
          live_r[idx_r] <= !win_done;
          state_r       <= win_done ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_sample;
      chan_r   <= in_channel;
      idx_r    <= IDX_W'(in_channel);
      start_r  <= in_window_start;
    end
    if (div_start) begin
      pend_chan_r <= chan_r;
      pend_len_r  <= upd_rec.len_sum;
      pend_ext_r  <= upd_rec.ext_cnt;
      pend_zc_r   <= upd_rec.zc_cnt;
    end
    if (out_load) begin
      out_chan_r <= pend_chan_r;
      out_mean_r <= div_quo;
      out_len_r  <= pend_len_r;
      out_ext_r  <= pend_ext_r;
      out_zc_r   <= pend_zc_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_chan_r;
  assign out_mean_abs       = out_mean_r;
  assign out_wave_length    = out_len_r;
  assign out_slope_changes  = out_ext_r;
  assign out_zero_crossings = out_zc_r;

endmodule

>>> tb/emg_time_domain_features_core_tb.sv
// ----------------------------------------------------------------------------
// emg_time_domain_features_core_tb: self-checking bench for the EMG features
// Opens with a table of hand-picked beats and register writes, then random
// sample traffic over several window and threshold settings. A bench-side
// feature predictor runs on every accepted beat, and each result beat is
// compared field by field with the oldest predicted window.
// ----------------------------------------------------------------------------
module emg_time_domain_features_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import etdf_pkg::*;

  localparam int NUM_CH       = CHANNELS_DEF;
  localparam int MAX_WIN      = MAX_WINDOW_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  // covers a window-closing beat (divider included) plus margin
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;

  // one completed window as it leaves the block
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [MEAN_W-1:0] mean;
    logic [SUM_W-1:0]  wl;
    logic [CNT_W-1:0]  sc;
    logic [CNT_W-1:0]  zc;
  } features_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // directed row: a sample beat or a register write; typed rows carry the
  // window result as worked out by hand
  typedef struct packed {
    row_kind_t            kind;
    logic                 idx;
    logic [SAMPLE_W-1:0]  value;
    logic [CHAN_W-1:0]    chan;
    logic                 start;
    logic                 typed;
    features_t            want;
  } row_t;

  localparam features_t NONE = '0;
  localparam int NUM_ROWS = 31;

  localparam row_t DIRECTED [NUM_ROWS] = '{
    // smallest window, no threshold
    '{ROW_CFG,  CFG_WINDOW_SIZE,  16'd3,       3'd0, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  CFG_ZC_THRESHOLD, 16'd0,       3'd0, 1'b0, 1'b0, NONE},
    // full-scale swings: two crossings, one extremum
    '{ROW_BEAT, 1'b0, 16'h7FFF, 3'd0, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'h8000, 3'd0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'h7FFF, 3'd0, 1'b0, 1'b1,
      '{3'd0, 24'd8388437, 26'd131070, 10'd1, 10'd2}},
    // all zero, empty channel opened without a start mark
    '{ROW_BEAT, 1'b0, 16'h0000, 3'd1, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'h0000, 3'd1, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'h0000, 3'd1, 1'b0, 1'b1,
      '{3'd1, 24'd0, 26'd0, 10'd0, 10'd0}},
    // most negative sample on the top channel: largest mean
    '{ROW_BEAT, 1'b0, 16'h8000, 3'd7, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'h8000, 3'd7, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'h8000, 3'd7, 1'b0, 1'b1,
      '{3'd7, 24'd8388608, 26'd0, 10'd0, 10'd0}},
    // start mark mid-window throws the partial window away
    '{ROW_BEAT, 1'b0, 16'd100,  3'd2, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd200,  3'd2, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd5,    3'd2, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd6,    3'd2, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd7,    3'd2, 1'b0, 1'b0, NONE},
    // shrink the window while channel 4 is part way through
    '{ROW_CFG,  CFG_WINDOW_SIZE,  16'd5,       3'd0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd1,      3'd4, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'(-3),    3'd4, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd2,      3'd4, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'(-1),    3'd4, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  CFG_WINDOW_SIZE,  16'd0,       3'd0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd4,      3'd4, 1'b0, 1'b0, NONE},
    // threshold: raw seed sign, small samples count as zero
    '{ROW_CFG,  CFG_ZC_THRESHOLD, 16'd1000,    3'd0, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd500,    3'd5, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'(-500),  3'd5, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'(-2000), 3'd5, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd0,      3'd6, 1'b1, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd2000,   3'd6, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'(-2000), 3'd6, 1'b0, 1'b0, NONE},
    '{ROW_BEAT, 1'b0, 16'd999,    3'd6, 1'b1, 1'b0, NONE}
  };

  // random phases: register settings, beat count, long single-channel window,
  // idle-free tail
  typedef struct packed {
    logic [THR_W-1:0] win;
    logic [THR_W-1:0] thr;
    int               items;
    bit               big;
    bit               quiet;
  } phase_t;

  localparam int NUM_PHASES = 10;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{15'd3,    15'd0,     40,   1'b0, 1'b0},
    '{15'd4,    15'd32767, 18,   1'b0, 1'b0},
    '{15'd7,    15'd150,   18,   1'b0, 1'b0},
    '{15'd2,    15'd3000,  18,   1'b0, 1'b0},
    '{15'd12,   15'd20000, 18,   1'b0, 1'b0},
    '{15'd5,    15'd0,     18,   1'b0, 1'b0},
    '{15'd30,   15'd500,   18,   1'b0, 1'b0},
    '{15'd6,    15'd1,     18,   1'b0, 1'b0},
    '{15'd2047, 15'd0,     1024, 1'b1, 1'b0},
    '{15'd3,    15'd10,    40,   1'b0, 1'b1}
  };

  // --------------------------------------------------------------------------
  // DUT ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n           = 1'b0;
  logic                cfg_we          = 1'b0;
  logic                cfg_index       = 1'b0;
  logic [THR_W-1:0]    cfg_data        = '0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample       = '0;
  logic [CHAN_W-1:0]   in_channel      = '0;
  logic                in_window_start = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [CHAN_W-1:0]   out_channel;
  logic [MEAN_W-1:0]   out_mean_abs;
  logic [SUM_W-1:0]    out_wave_length;
  logic [CNT_W-1:0]    out_slope_changes;
  logic [CNT_W-1:0]    out_zero_crossings;

  emg_time_domain_features_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_channel         (in_channel),
    .in_window_start    (in_window_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel        (out_channel),
    .out_mean_abs       (out_mean_abs),
    .out_wave_length    (out_wave_length),
    .out_slope_changes  (out_slope_changes),
    .out_zero_crossings (out_zero_crossings)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Feature predictor: its own copy of the registers and channel windows
  // --------------------------------------------------------------------------
  logic [WIN_W-1:0]           win_reg = WIN_RESET;
  logic [THR_W-1:0]           thr_reg = '0;
  logic [WIN_W-1:0]           win_cnt  [NUM_CH];
  logic [SUM_W-1:0]           abs_acc  [NUM_CH];
  logic [SUM_W-1:0]           len_acc  [NUM_CH];
  logic [CNT_W-1:0]           ext_acc  [NUM_CH];
  logic [CNT_W-1:0]           zc_acc   [NUM_CH];
  logic signed [SAMPLE_W-1:0] prev_smp [NUM_CH];
  logic signed [SAMPLE_W-1:0] old_smp  [NUM_CH];
  sign_t                      zc_sign  [NUM_CH];

  features_t pending_features [$];

  int mismatches      = 0;
  int beats_sent      = 0;
  int windows_checked = 0;
  int reg_writes      = 0;
  int run_left        = 0;
  int hold_left       = 0;
  bit hold_req        = 1'b0;
  bit quiet           = 1'b0;

  function automatic longint sat_add(longint a, longint b, longint lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic sign_t sign_of(int v);
    return (v > 0) ? SIGN_POS : ((v < 0) ? SIGN_NEG : SIGN_NONE);
  endfunction

  // Advance one channel by one sample; flag and build the result when the
  // window closes.
  function automatic void predict_features(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [CHAN_W-1:0] ch,
                                           input logic start,
                                           output bit done, output features_t res);
    int          x, b, t, d1, d2, m, dm;
    int unsigned w;
    longint      mean;
    sign_t       ts;
    done = 1'b0;
    res  = '0;
    x = int'(smp);
    m = (x < 0) ? -x : x;
    w = 32'(win_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIN) w = MAX_WIN;
    if (ch >= NUM_CH) return;
    if (start || win_cnt[ch] == 0) begin
      // open a fresh window; the raw sample seeds the sign
      win_cnt[ch]  = WIN_W'(1);
      abs_acc[ch]  = SUM_W'(m);
      len_acc[ch]  = '0;
      ext_acc[ch]  = '0;
      zc_acc[ch]   = '0;
      old_smp[ch]  = '0;
      prev_smp[ch] = smp;
      zc_sign[ch]  = sign_of(x);
    end else begin
      b  = int'(prev_smp[ch]);
      t  = (m < int'(thr_reg)) ? 0 : x;
      ts = sign_of(t);
      dm = (x - b < 0) ? b - x : x - b;
      abs_acc[ch] = SUM_W'(sat_add(abs_acc[ch], m, SUM_MAX));
      len_acc[ch] = SUM_W'(sat_add(len_acc[ch], dm, SUM_MAX));
      if (win_cnt[ch] >= 2) begin
        d1 = b - x;
        d2 = b - int'(old_smp[ch]);
        if ((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0))
          ext_acc[ch] = CNT_W'(sat_add(ext_acc[ch], 1, CNT_MAX));
      end
      if (zc_sign[ch] == SIGN_NONE) begin
        zc_sign[ch] = ts;
      end else if (ts != SIGN_NONE && ts != zc_sign[ch]) begin
        zc_acc[ch]  = CNT_W'(sat_add(zc_acc[ch], 1, CNT_MAX));
        zc_sign[ch] = ts;
      end
      old_smp[ch]  = prev_smp[ch];
      prev_smp[ch] = smp;
      if (win_cnt[ch] < WIN_REG_MAX) win_cnt[ch]++;
    end
    if (win_cnt[ch] >= w) begin
      mean = longint'(abs_acc[ch]) * 256 / w;
      if (mean > longint'(MEAN_MAX)) mean = longint'(MEAN_MAX);
      res.chan = ch;
      res.mean = mean[MEAN_W-1:0];
      res.wl   = len_acc[ch];
      res.sc   = ext_acc[ch];
      res.zc   = zc_acc[ch];
      win_cnt[ch] = '0;
      done = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Offer one beat, hold it until taken, then predict. Typed rows push the
  // hand-computed window instead of the predicted one.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch,
                             input logic start, input logic typed, input features_t want);
    int        gap;
    bit        done;
    features_t res;
    gap = 0;
    if (!quiet) begin
      if (run_left == 0) begin
        gap      = $urandom_range(1, 16);
        run_left = $urandom_range(0, 40);
      end else begin
        run_left--;
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= smp;
    in_channel      <= ch;
    in_window_start <= start;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    predict_features(smp, ch, start, done, res);
    if (done) pending_features.push_back(typed ? want : res);
  endtask

  // Pause the sender until every predicted window is out, then let the
  // block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [THR_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) win_reg = data[WIN_W-1:0];
    else thr_reg = data;
    reg_writes++;
  endtask

  // Mix of full-range noise, extremes, values around the threshold and tiny
  // values that make ties in the slope test.
  function automatic logic [SAMPLE_W-1:0] pick_sample(int thr);
    int v;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      2: begin
        v = thr + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1) == 1) v = -v;
        return 16'(v);
      end
      default: begin
        v = int'($urandom_range(0, 16)) - 8;
        return 16'(v);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CHAN_W-1:0]   ch;
    logic                st;
    logic [SAMPLE_W-1:0] smp;
    for (int c = 0; c < NUM_CH; c++) begin
      win_cnt[c]  = '0;
      abs_acc[c]  = '0;
      len_acc[c]  = '0;
      ext_acc[c]  = '0;
      zc_acc[c]   = '0;
      prev_smp[c] = '0;
      old_smp[c]  = '0;
      zc_sign[c]  = SIGN_NONE;
    end

    // hold reset, then release it once for the whole run
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_reg(DIRECTED[r].idx, DIRECTED[r].value[THR_W-1:0]);
      end else begin
        send_sample(DIRECTED[r].value, DIRECTED[r].chan, DIRECTED[r].start,
                    DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // random phases; registers change only with the block idle, windows
    // left part way through carry into the next setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_WINDOW_SIZE, PHASES[p].win);
      write_reg(CFG_ZC_THRESHOLD, PHASES[p].thr);
      quiet = PHASES[p].quiet;
      for (int i = 0; i < PHASES[p].items; i++) begin
        // long receiver hold-off early in the smallest window: the output
        // register fills and the block must stall its input
        if (p == 0 && i == 10) hold_req = 1'b1;
        // sender pause until every window is out
        if (p == 4 && i == 9) drain();
        if (PHASES[p].big) begin
          // one full-length window on a single channel, mostly full-scale swings
          ch = 3'd3;
          st = (i == 0);
          if ($urandom_range(0, 7) == 0) smp = pick_sample(0);
          else smp = i[0] ? 16'h8000 : 16'h7FFF;
        end else begin
          ch = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, NUM_CH - 1))
                                           : 3'($urandom_range(0, 2));
          // well-formed windows mostly; occasional stray start marks and
          // channels opened without one
          if (win_cnt[ch] == 0) st = ($urandom_range(0, 7) != 0);
          else st = ($urandom_range(0, 19) == 0);
          smp = pick_sample(int'(PHASES[p].thr));
        end
        send_sample(smp, ch, st, 1'b0, NONE);
      end
    end

    // wind down: wait for the last windows, then let the block go quiet
    in_valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d sample beats, %0d checked windows, %0d register writes,",
             beats_sent, windows_checked, reg_writes);
    $display("with window sizes 3 to 1024 (clamped values included) and thresholds 0 to 32767.");
    if (mismatches == 0 && pending_features.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off, none in the tail
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned left;
    bit          stalling;
    left     = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          left     = stalling ? $urandom_range(1, 16) : $urandom_range(1, 48);
        end
        out_stall <= stalling;
        left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: compare every accepted beat with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    features_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_features.size() == 0) begin
        report_mismatch("result beat with no window pending, channel", out_channel, -1);
      end else begin
        want = pending_features.pop_front();
        windows_checked++;
        if (out_channel !== want.chan)
          report_mismatch("out_channel", out_channel, want.chan);
        if (out_mean_abs !== want.mean)
          report_mismatch("out_mean_abs", out_mean_abs, want.mean);
        if (out_wave_length !== want.wl)
          report_mismatch("out_wave_length", out_wave_length, want.wl);
        if (out_slope_changes !== want.sc)
          report_mismatch("out_slope_changes", out_slope_changes, want.sc);
        if (out_zero_crossings !== want.zc)
          report_mismatch("out_zero_crossings", out_zero_crossings, want.zc);
      end
    end
  end

  // Timeout: drop out of a hung run.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles, %0d windows still pending",
             LIMIT_CYCLES, pending_features.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
